/* sv/pnr_pkg.sv */
// ----------------------------------------------------------------------------
// pnr_pkg
// Shared types, codes and field positions of the parallel-cable nibble
// receiver and its checker.
// ----------------------------------------------------------------------------
package pnr_pkg;

    // bytes of link header ahead of the payload
    localparam int unsigned HEADER_LEN = 14;

    localparam logic [15:0] MTU_RESET        = 16'd1500;
    localparam logic [15:0] SPIN_LIMIT_RESET = 16'd500;
    localparam logic [7:0]  MAX_ERRORS_RESET = 8'd100;

    // status bits
    localparam int unsigned SHAKE_BIT = 7;
    localparam int unsigned NIB_HI    = 6;
    localparam int unsigned NIB_LO    = 3;

    // values driven on the data lines
    localparam logic [7:0] DRIVE_IDLE = 8'h00;
    localparam logic [7:0] DRIVE_ACK  = 8'h01;
    localparam logic [7:0] DRIVE_LOW  = 8'h10;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MTU        = 2'd0,
        REG_SPIN_LIMIT = 2'd1,
        REG_MAX_ERRORS = 2'd2,
        REG_LINK_UP    = 2'd3
    } reg_index_t;

    // error causes
    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_TIMEOUT   = 2'd1,
        CAUSE_TOO_LONG  = 2'd2,
        CAUSE_TOO_SHORT = 2'd3
    } cause_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT_LOW  = 3'b010,
        PH_WAIT_HIGH = 3'b100
    } phase_t;

    // part of the frame being received
    typedef enum logic [1:0] {
        SECT_LEN_LO   = 2'd0,
        SECT_LEN_HI   = 2'd1,
        SECT_DATA     = 2'd2,
        SECT_CHECKSUM = 2'd3
    } section_t;

    // input tdata layout
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned S_REQUEST   = 0;
    localparam int unsigned S_STATUS_LO = 1;

    // output tdata layout
    localparam int unsigned M_TDATA_W    = 24;
    localparam int unsigned M_DRIVE_LO   = 0;
    localparam int unsigned M_IRQ_EN     = 8;
    localparam int unsigned M_BYTE_VALID = 9;
    localparam int unsigned M_BYTE_LO    = 10;
    localparam int unsigned M_FRAME_ERR  = 18;
    localparam int unsigned M_CAUSE_LO   = 19;
    localparam int unsigned M_OFFLINE    = 21;
    localparam int unsigned M_BUSY       = 22;

endpackage

/* sv/plip_nibble_receiver.sv */
// ----------------------------------------------------------------------------
// plip_nibble_receiver
// Nibble-mode receiver of a parallel-cable link, one status sample per
// transfer on the input stream and one result per sample on the output.
// ----------------------------------------------------------------------------
// Each input transfer carries one port sample: the remote request flag and
// the status byte. The block answers every sample with one result transfer:
// the value to drive on the data lines, the interrupt enable, an optional
// payload byte (tlast marks the end of the frame payload), a frame abort
// with its cause, an offline flag and the busy flag.
// The result is registered and appears in the cycle after its input transfer;
// one sample is taken per cycle unless the result side stalls. Frame state and
// result register update in the same cycle, so polling runs at one poll per sample.
// The output register decouples the two sides: a new sample is taken while
// a result is held only if that result is taken in the same cycle; while the
// result side stalls, s_axis_tready stays low.
// Reset returns the configuration to mtu 1500, spin limit 500, max errors 100
// with the link down, clears the frame state and empties the result register.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
// writing link_up clears the offline state, and a write of 0 drops any frame.
// ----------------------------------------------------------------------------
module plip_nibble_receiver
    import pnr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request [0], status [8:1], zero fill [15:9]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // data_drive [7:0], irq_enable [8], byte_valid [9], byte_value [17:10],
    // frame_error [18], error_cause [20:19], went_offline [21], busy_res [22],
    // zero fill [23]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    logic [15:0] mtu_reg, mtu_next;
    logic [15:0] spin_reg, spin_next;
    logic [7:0]  maxerr_reg, maxerr_next;
    logic        link_reg, link_next;
    phase_t      phase_reg, phase_next;
    section_t    sect_reg, sect_next;
    logic [15:0] budget_reg, budget_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] brx_reg, brx_next;
    logic [7:0]  errcnt_reg, errcnt_next;
    logic        offline_reg, offline_next;
    logic [7:0]  drive_reg, drive_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    logic        accept;
    logic        request;
    logic [7:0]  status;
    logic [7:0]  rx_byte;
    logic [15:0] budget_dec;
    logic [15:0] flen_full;
    logic [16:0] len_limit;
    logic [15:0] brx_inc;
    logic [8:0]  errcnt_inc;
    logic        do_abort;
    cause_t      abort_cause;
    logic        o_bvalid, o_last, o_off;
    logic [7:0]  o_byte;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign request       = s_axis_tdata[S_REQUEST];
    assign status        = s_axis_tdata[S_STATUS_LO +: 8];

    assign rx_byte    = {status[NIB_HI:NIB_LO], low_reg[NIB_HI:NIB_LO]};
    assign budget_dec = budget_reg - 16'd1;
    assign flen_full  = {rx_byte, flen_reg[7:0]};
    assign len_limit  = {1'b0, mtu_reg} + 17'(HEADER_LEN);
    assign brx_inc    = brx_reg + 16'd1;
    assign errcnt_inc = {1'b0, errcnt_reg} + 9'd1;

    always_comb begin
        mtu_next     = mtu_reg;
        spin_next    = spin_reg;
        maxerr_next  = maxerr_reg;
        link_next    = link_reg;
        phase_next   = phase_reg;
        sect_next    = sect_reg;
        budget_next  = budget_reg;
        low_next     = low_reg;
        flen_next    = flen_reg;
        brx_next     = brx_reg;
        errcnt_next  = errcnt_reg;
        offline_next = offline_reg;
        drive_next   = drive_reg;
        do_abort     = 1'b0;
        abort_cause  = CAUSE_NONE;
        o_bvalid     = 1'b0;
        o_byte       = 8'd0;
        o_last       = 1'b0;
        o_off        = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (request && link_reg && !offline_reg) begin
                        drive_next  = DRIVE_ACK;
                        phase_next  = PH_WAIT_LOW;
                        budget_next = spin_reg;
                        sect_next   = SECT_LEN_LO;
                        flen_next   = 16'd0;
                        brx_next    = 16'd0;
                    end
                end
                PH_WAIT_LOW: begin
                    if (status[SHAKE_BIT]) begin
                        budget_next = budget_dec;
                        if (budget_dec == 16'd0) begin
                            do_abort    = 1'b1;
                            abort_cause = CAUSE_TIMEOUT;
                        end
                    end else begin
                        low_next   = status;
                        drive_next = DRIVE_LOW;
                        phase_next = PH_WAIT_HIGH;
                    end
                end
                PH_WAIT_HIGH: begin
                    if (!status[SHAKE_BIT]) begin
                        budget_next = budget_dec;
                        if (budget_dec == 16'd0) begin
                            do_abort    = 1'b1;
                            abort_cause = CAUSE_TIMEOUT;
                        end
                    end else begin
                        drive_next  = DRIVE_IDLE;
                        phase_next  = PH_WAIT_LOW;
                        budget_next = spin_reg;
                        unique case (sect_reg)
                            SECT_LEN_LO: begin
                                flen_next = {8'd0, rx_byte};
                                sect_next = SECT_LEN_HI;
                            end
                            SECT_LEN_HI: begin
                                flen_next = flen_full;
                                if ({1'b0, flen_full} > len_limit) begin
                                    do_abort    = 1'b1;
                                    abort_cause = CAUSE_TOO_LONG;
                                end else if (flen_full == 16'd0) begin
                                    sect_next = SECT_CHECKSUM;
                                end else begin
                                    sect_next = SECT_DATA;
                                end
                            end
                            SECT_DATA: begin
                                brx_next = brx_inc;
                                if (brx_reg >= 16'(HEADER_LEN)) begin
                                    o_bvalid = 1'b1;
                                    o_byte   = rx_byte;
                                    o_last   = (brx_inc == flen_reg);
                                end
                                if (brx_inc == flen_reg) begin
                                    sect_next = SECT_CHECKSUM;
                                end
                            end
                            SECT_CHECKSUM: begin
                                if (flen_reg <= 16'(HEADER_LEN)) begin
                                    do_abort    = 1'b1;
                                    abort_cause = CAUSE_TOO_SHORT;
                                end else begin
                                    errcnt_next = 8'd0;
                                    phase_next  = PH_IDLE;
                                end
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_abort) begin
                drive_next = DRIVE_IDLE;
                phase_next = PH_IDLE;
                if (errcnt_inc > {1'b0, maxerr_reg}) begin
                    offline_next = 1'b1;
                    errcnt_next  = 8'd0;
                    o_off        = 1'b1;
                end else begin
                    errcnt_next = errcnt_inc[7:0];
                end
            end
        end

        // register writes are to arrive only while idle; the block itself does not enforce this
        if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_MTU:        mtu_next    = cfg_wdata;
                REG_SPIN_LIMIT: spin_next   = cfg_wdata;
                REG_MAX_ERRORS: maxerr_next = cfg_wdata[7:0];
                REG_LINK_UP: begin
                    link_next    = cfg_wdata[0];
                    offline_next = 1'b0;
                    if (!cfg_wdata[0]) begin
                        phase_next = PH_IDLE;
                        drive_next = DRIVE_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_last_next  = o_last;
            m_data_next  = '0;
            m_data_next[M_DRIVE_LO +: 8] = drive_next;
            m_data_next[M_IRQ_EN]        = link_reg && !offline_next;
            m_data_next[M_BYTE_VALID]    = o_bvalid;
            m_data_next[M_BYTE_LO +: 8]  = o_byte;
            m_data_next[M_FRAME_ERR]     = do_abort;
            m_data_next[M_CAUSE_LO +: 2] = abort_cause;
            m_data_next[M_OFFLINE]       = o_off;
            m_data_next[M_BUSY]          = (phase_next != PH_IDLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg     <= MTU_RESET;
            spin_reg    <= SPIN_LIMIT_RESET;
            maxerr_reg  <= MAX_ERRORS_RESET;
            link_reg    <= 1'b0;
            phase_reg   <= PH_IDLE;
            sect_reg    <= SECT_LEN_LO;
            budget_reg  <= 16'd0;
            low_reg     <= 8'd0;
            flen_reg    <= 16'd0;
            brx_reg     <= 16'd0;
            errcnt_reg  <= 8'd0;
            offline_reg <= 1'b0;
            drive_reg   <= DRIVE_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            mtu_reg     <= mtu_next;
            spin_reg    <= spin_next;
            maxerr_reg  <= maxerr_next;
            link_reg    <= link_next;
            phase_reg   <= phase_next;
            sect_reg    <= sect_next;
            budget_reg  <= budget_next;
            low_reg     <= low_next;
            flen_reg    <= flen_next;
            brx_reg     <= brx_next;
            errcnt_reg  <= errcnt_next;
            offline_reg <= offline_next;
            drive_reg   <= drive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* sv/pnr_checker.sv */
// ----------------------------------------------------------------------------
// pnr_checker
// Port-level checks of the nibble receiver's result stream.
// ----------------------------------------------------------------------------
module pnr_checker
    import pnr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready
);

    logic       bvalid, ferr, off, busy, irq;
    logic [1:0] cause;
    logic [7:0] bval;

    assign bvalid = m_axis_tdata[M_BYTE_VALID];
    assign bval   = m_axis_tdata[M_BYTE_LO +: 8];
    assign ferr   = m_axis_tdata[M_FRAME_ERR];
    assign cause  = m_axis_tdata[M_CAUSE_LO +: 2];
    assign off    = m_axis_tdata[M_OFFLINE];
    assign busy   = m_axis_tdata[M_BUSY];
    assign irq    = m_axis_tdata[M_IRQ_EN];

    // an aborted frame always names its cause and leaves the receiver idle
    a_abort_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ferr |-> cause != CAUSE_NONE && !busy)
        else $error("abort without cause or still busy");

    a_cause_only_on_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !ferr |-> cause == CAUSE_NONE && !off)
        else $error("cause or offline without abort");

    // going offline drops the interrupt enable
    a_offline_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && off |-> !irq)
        else $error("interrupt still enabled after going offline");

    a_no_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !bvalid |-> bval == 8'd0 && !m_axis_tlast)
        else $error("payload fields set without a byte");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind plip_nibble_receiver pnr_checker u_pnr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parallel-cable nibble receiver: drives port
// samples as whole frames (good, too short, too long, handshake timeouts,
// broken sequences, noise) and compares every result transfer field by
// field with a sample-by-sample prediction of the receiver state.
// ----------------------------------------------------------------------------
module tb;
    import pnr_pkg::*;

    localparam int CYCLE_LIMIT = 300_000;

    typedef struct packed {
        logic [7:0] drive;
        logic       irq_en;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_last;
        logic       frame_err;
        cause_t     cause;
        logic       went_off;
        logic       busy;
    } rx_result_t;

    typedef enum {FR_GOOD, FR_TOO_SHORT, FR_TOO_LONG, FR_TIMEOUT, FR_BROKEN, FR_NOISE}
        frame_kind_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [1:0]           cfg_index     = '0;
    logic [15:0]          cfg_wdata     = '0;

    plip_nibble_receiver u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver state as the bench sees it
    logic [15:0] reg_mtu       = MTU_RESET;
    logic [15:0] reg_spin      = SPIN_LIMIT_RESET;
    logic [7:0]  reg_max_err   = MAX_ERRORS_RESET;
    logic        reg_link      = 1'b0;
    phase_t      rx_phase      = PH_IDLE;
    section_t    rx_section    = SECT_LEN_LO;
    logic [15:0] rx_budget     = '0;
    logic [7:0]  rx_low_sample = '0;
    logic [15:0] rx_length     = '0;
    logic [15:0] rx_count      = '0;
    logic [7:0]  rx_err_count  = '0;
    logic        rx_offline    = 1'b0;
    logic [7:0]  rx_drive      = DRIVE_IDLE;

    rx_result_t expected_results[$];
    int         fail_count         = 0;
    int         results_seen       = 0;
    int         samples_sent       = 0;
    int         cycle_count        = 0;
    logic       went_offline_seen  = 1'b0;
    logic       gap_enable         = 1'b1;
    logic       stall_enable       = 1'b1;

    function automatic void abort_frame(input cause_t why, inout rx_result_t res);
        logic [8:0] next;
        next          = rx_err_count + 9'd1;
        rx_drive      = DRIVE_IDLE;
        rx_phase      = PH_IDLE;
        res.frame_err = 1'b1;
        res.cause     = why;
        if (next > reg_max_err) begin
            rx_offline   = 1'b1;
            rx_err_count = '0;
            res.went_off = 1'b1;
        end else begin
            rx_err_count = next[7:0];
        end
    endfunction

    function automatic void apply_config(input logic [1:0] idx, input logic [15:0] val);
        case (reg_index_t'(idx))
            REG_MTU:        reg_mtu = val;
            REG_SPIN_LIMIT: reg_spin = val;
            REG_MAX_ERRORS: reg_max_err = val[7:0];
            REG_LINK_UP: begin
                reg_link   = val[0];
                rx_offline = 1'b0;
                if (!val[0]) begin
                    rx_phase = PH_IDLE;
                    rx_drive = DRIVE_IDLE;
                end
            end
        endcase
    endfunction

    function automatic rx_result_t predict_sample(input logic req, input logic [7:0] status);
        rx_result_t  res;
        logic [7:0]  b;
        logic        more;
        logic [15:0] idx;
        res = '0;
        case (rx_phase)
            PH_IDLE: begin
                if (req && reg_link && !rx_offline) begin
                    rx_drive   = DRIVE_ACK;
                    rx_phase   = PH_WAIT_LOW;
                    rx_budget  = reg_spin;
                    rx_section = SECT_LEN_LO;
                    rx_length  = '0;
                    rx_count   = '0;
                end
            end
            PH_WAIT_LOW: begin
                if (status[SHAKE_BIT]) begin
                    rx_budget = rx_budget - 16'd1;
                    if (rx_budget == 16'd0)
                        abort_frame(CAUSE_TIMEOUT, res);
                end else begin
                    rx_low_sample = status;
                    rx_drive      = DRIVE_LOW;
                    rx_phase      = PH_WAIT_HIGH;
                end
            end
            default: begin
                if (!status[SHAKE_BIT]) begin
                    rx_budget = rx_budget - 16'd1;
                    if (rx_budget == 16'd0)
                        abort_frame(CAUSE_TIMEOUT, res);
                end else begin
                    b        = {status[NIB_HI:NIB_LO], rx_low_sample[NIB_HI:NIB_LO]};
                    more     = 1'b1;
                    rx_drive = DRIVE_IDLE;
                    case (rx_section)
                        SECT_LEN_LO: begin
                            rx_length  = {8'h00, b};
                            rx_section = SECT_LEN_HI;
                        end
                        SECT_LEN_HI: begin
                            rx_length[15:8] = b;
                            if (32'(rx_length) > 32'(reg_mtu) + HEADER_LEN) begin
                                abort_frame(CAUSE_TOO_LONG, res);
                                more = 1'b0;
                            end else begin
                                rx_section = (rx_length != 0) ? SECT_DATA : SECT_CHECKSUM;
                            end
                        end
                        SECT_DATA: begin
                            idx      = rx_count;
                            rx_count = rx_count + 16'd1;
                            if (idx >= HEADER_LEN) begin
                                res.byte_valid = 1'b1;
                                res.byte_value = b;
                                res.byte_last  = (rx_count == rx_length);
                            end
                            if (rx_count == rx_length)
                                rx_section = SECT_CHECKSUM;
                        end
                        default: begin
                            // checksum byte is ignored, only the length is judged here
                            if (rx_length <= HEADER_LEN) begin
                                abort_frame(CAUSE_TOO_SHORT, res);
                            end else begin
                                rx_err_count = '0;
                                rx_phase     = PH_IDLE;
                            end
                            more = 1'b0;
                        end
                    endcase
                    if (more) begin
                        rx_phase  = PH_WAIT_LOW;
                        rx_budget = reg_spin;
                    end
                end
            end
        endcase
        res.drive  = rx_drive;
        res.irq_en = reg_link && !rx_offline;
        res.busy   = (rx_phase != PH_IDLE);
        return res;
    endfunction

    always @(posedge aclk) begin : predictor
        rx_result_t r;
        if (aresetn) begin
            if (cfg_we)
                apply_config(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                r = predict_sample(s_axis_tdata[S_REQUEST], s_axis_tdata[S_STATUS_LO +: 8]);
                expected_results.push_back(r);
                if (r.went_off)
                    went_offline_seen = 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s 0x%0h, expected 0x%0h",
                                    results_seen, name, got, want));
    endtask

    task automatic check_result(input rx_result_t want);
        rx_result_t got;
        got.drive      = m_axis_tdata[M_DRIVE_LO +: 8];
        got.irq_en     = m_axis_tdata[M_IRQ_EN];
        got.byte_valid = m_axis_tdata[M_BYTE_VALID];
        got.byte_value = m_axis_tdata[M_BYTE_LO +: 8];
        got.byte_last  = m_axis_tlast;
        got.frame_err  = m_axis_tdata[M_FRAME_ERR];
        got.cause      = cause_t'(m_axis_tdata[M_CAUSE_LO +: 2]);
        got.went_off   = m_axis_tdata[M_OFFLINE];
        got.busy       = m_axis_tdata[M_BUSY];
        compare_field("data_drive", got.drive, want.drive);
        compare_field("irq_enable", got.irq_en, want.irq_en);
        compare_field("byte_valid", got.byte_valid, want.byte_valid);
        compare_field("byte_value", got.byte_value, want.byte_value);
        compare_field("last_byte", got.byte_last, want.byte_last);
        compare_field("frame_error", got.frame_err, want.frame_err);
        compare_field("error_cause", got.cause, want.cause);
        compare_field("went_offline", got.went_off, want.went_off);
        compare_field("busy_res", got.busy, want.busy);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0)
                note_mismatch($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
            else
                check_result(expected_results.pop_front());
            results_seen++;
        end
    end

    always @(posedge aclk)
        m_axis_tready <= !(stall_enable && ($urandom_range(0, 99) < 10));

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] make_status(input logic shake, input logic [3:0] nib);
        return {shake, nib, 3'($urandom)};
    endfunction

    // request flag on samples where the receiver should ignore it
    function automatic logic noise_req();
        return ($urandom_range(0, 3) == 0);
    endfunction

    task automatic send_sample(input logic req, input logic [7:0] status);
        logic [S_TDATA_W-1:0] word;
        word                   = '0;
        word[S_REQUEST]        = req;
        word[S_STATUS_LO +: 8] = status;
        if (gap_enable && ($urandom_range(0, 99) < 5)) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] mtu, input logic [15:0] spin,
                              input logic [7:0] max_err);
        cfg_write(REG_MTU, mtu);
        cfg_write(REG_SPIN_LIMIT, spin);
        cfg_write(REG_MAX_ERRORS, {8'h00, max_err});
    endtask

    // one byte as two nibbles, with a little handshake slack inside the budget
    task automatic send_byte(input logic [7:0] b);
        int extra, early, i;
        extra = 0;
        if (reg_spin > 1 && $urandom_range(0, 9) == 0)
            extra = $urandom_range(1, (reg_spin > 5) ? 4 : reg_spin - 1);
        early = $urandom_range(0, extra);
        for (i = 0; i < early; i++)
            send_sample(noise_req(), make_status(1'b1, 4'($urandom)));
        send_sample(noise_req(), make_status(1'b0, b[3:0]));
        for (i = early; i < extra; i++)
            send_sample(noise_req(), make_status(1'b0, 4'($urandom)));
        send_sample(noise_req(), make_status(1'b1, b[7:4]));
    endtask

    // spend the whole budget of one byte, split between the two nibbles
    task automatic time_out_byte();
        int early, i;
        early = $urandom_range(0, reg_spin);
        for (i = 0; i < early; i++)
            send_sample(noise_req(), make_status(1'b1, 4'($urandom)));
        if (early < reg_spin) begin
            send_sample(noise_req(), make_status(1'b0, 4'($urandom)));
            for (i = early; i < reg_spin; i++)
                send_sample(noise_req(), make_status(1'b0, 4'($urandom)));
        end
    endtask

    // request, length, body and checksum; cut is the byte where a timeout
    // or a broken sequence starts
    task automatic send_frame(input frame_kind_t kind, input int len, input int cut);
        int         n_seq, k, i;
        logic [7:0] b;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 4)) send_sample(1'b0, 8'($urandom));
            return;
        end
        send_sample(1'b1, 8'($urandom));
        n_seq = (kind == FR_TOO_LONG) ? 2 : len + 3;
        for (k = 0; k < n_seq; k++) begin
            if (k == 0)
                b = len[7:0];
            else if (k == 1)
                b = len[15:8];
            else if ($urandom_range(0, 7) == 0)
                b = {8{1'($urandom)}};
            else
                b = 8'($urandom);
            if (k == cut && kind == FR_TIMEOUT) begin
                time_out_byte();
                return;
            end
            if (k == cut && kind == FR_BROKEN) begin
                repeat ($urandom_range(1, 6)) send_sample(1'($urandom), 8'($urandom));
                // a steady high handshake brings the receiver back to idle
                for (i = 0; i <= reg_spin; i++)
                    send_sample(1'b0, make_status(1'b1, 4'($urandom)));
                return;
            end
            send_byte(b);
        end
    endtask

    task automatic test_link_down();
        send_sample(1'b1, 8'h00);
        send_sample(1'b1, 8'hFF);
        send_sample(1'b0, 8'h7F);
        wait_drained();
    endtask

    task automatic test_minimal_frame();
        set_limits(16'd1, 16'd1, 8'd255);
        cfg_write(REG_LINK_UP, 16'd1);
        send_frame(FR_GOOD, HEADER_LEN + 1, 0);
        wait_drained();
    endtask

    task automatic test_frame_errors();
        send_frame(FR_TIMEOUT, HEADER_LEN + 1, 0);
        wait_drained();
        cfg_write(REG_MTU, 16'd0);
        send_frame(FR_TOO_LONG, HEADER_LEN + 1, 0);
        send_frame(FR_TOO_SHORT, 0, 0);
        send_frame(FR_TOO_SHORT, HEADER_LEN, 0);
        wait_drained();
    endtask

    task automatic test_offline();
        cfg_write(REG_MAX_ERRORS, 16'd0);
        send_frame(FR_TOO_SHORT, 0, 0);
        send_sample(1'b1, 8'h00);
        wait_drained();
        cfg_write(REG_LINK_UP, 16'd1);
        cfg_write(REG_MAX_ERRORS, 16'd255);
        cfg_write(REG_MTU, MTU_RESET);
        send_frame(FR_GOOD, HEADER_LEN + 2, 0);
        wait_drained();
    endtask

    // largest length with the widest mtu and spin limits, then a silent drop of the link
    task automatic test_link_drop();
        set_limits(16'd65521, 16'hFFFF, 8'd100);
        send_sample(1'b1, 8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (3) send_sample(1'b0, make_status(1'b1, 4'($urandom)));
        wait_drained();
        cfg_write(REG_LINK_UP, 16'd0);
        send_sample(1'b1, 8'h80);
        wait_drained();
        cfg_write(REG_LINK_UP, 16'd1);
        send_frame(FR_GOOD, HEADER_LEN + 3, 0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input logic [15:0] mtu, input logic [15:0] spin,
                                       input logic [7:0] max_err, input int n_items,
                                       input logic idling);
        int          stop_at, r, len, cut, limit;
        frame_kind_t kind;
        wait_drained();
        set_limits(mtu, spin, max_err);
        cfg_write(REG_LINK_UP, 16'd1);
        went_offline_seen = 1'b0;
        gap_enable        = idling;
        stall_enable      = idling;
        stop_at           = samples_sent + n_items;
        limit             = int'(mtu) + HEADER_LEN;
        while (samples_sent < stop_at) begin
            if (went_offline_seen) begin
                wait_drained();
                if (rx_offline)
                    cfg_write(REG_LINK_UP, 16'd1);
                went_offline_seen = 1'b0;
            end
            r   = $urandom_range(0, 99);
            len = HEADER_LEN + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                                 : $urandom_range(0, 12));
            if (len > limit)
                len = limit;
            kind = FR_GOOD;
            if (r < 10) begin
                kind = FR_TOO_SHORT;
                len  = $urandom_range(0, HEADER_LEN);
            end else if (r < 18 && limit < 65535) begin
                kind = FR_TOO_LONG;
                len  = $urandom_range(limit + 1, 65535);
            end else if (r < 28 && spin <= 64) begin
                kind = FR_TIMEOUT;
            end else if (r < 34 && spin <= 64) begin
                kind = FR_BROKEN;
            end else if (r < 38) begin
                kind = FR_NOISE;
            end
            cut = $urandom_range(0, len + 2);
            send_frame(kind, len, cut);
        end
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_link_down();
        test_minimal_frame();
        test_frame_errors();
        test_offline();
        test_link_drop();
        test_random_traffic(MTU_RESET, 16'd8, 8'd255, 300, 1'b1);
        test_random_traffic(16'd4, 16'd3, 8'd1, 200, 1'b0);
        test_random_traffic(16'd65521, 16'd65535, 8'd0, 230, 1'b1);
        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
sv/pnr_pkg.sv
sv/plip_nibble_receiver.sv
sv/pnr_checker.sv
sim/tb.sv
